FILE: rtl/p1305_pkg.sv
// shared types and constants for the poly1305 authenticator
`timescale 1ns / 1ps
package p1305_pkg;

    localparam int LIMB_W  = 26;
    localparam int ACC_W   = 27;
    localparam int SUM_W   = 28;
    localparam int COEF_W  = 29;
    localparam int ROW_W   = 60;
    localparam int CARRY_W = ROW_W - LIMB_W;
    localparam int FIN_W   = 32;
    localparam int NLIMB   = 5;

    localparam logic [LIMB_W-1:0] LIMB_MASK = 26'h3ffffff;
    localparam logic [LIMB_W-1:0] CLAMP_1   = 26'h3ffff03;
    localparam logic [LIMB_W-1:0] CLAMP_2   = 26'h3ffc0ff;
    localparam logic [LIMB_W-1:0] CLAMP_3   = 26'h3f03fff;
    localparam logic [LIMB_W-1:0] CLAMP_4   = 26'h00fffff;
    localparam logic [ACC_W-1:0]  HIBIT     = 27'(1 << 24);
    localparam logic [FIN_W-1:0]  FIN_MASK  = 32'(1 << 26) - 32'd1;

    localparam logic [1:0] REG_R_LOW  = 2'd0;
    localparam logic [1:0] REG_R_HIGH = 2'd1;
    localparam logic [1:0] REG_S_LOW  = 2'd2;
    localparam logic [1:0] REG_S_HIGH = 2'd3;

    typedef struct packed {
        logic [NLIMB-1:0][LIMB_W-1:0] limb;
        logic                         hibit;
        logic                         absorb;
        logic                         last;
    } blk_item_t;

    typedef struct packed {
        logic [NLIMB-1:0][LIMB_W-1:0] r;
        logic [63:0]                  s_low;
        logic [63:0]                  s_high;
    } key_t;

    typedef struct packed {
        logic pop;
        logic acc_zero;
    } core_stat_t;

endpackage

FILE: rtl/p1305_front.sv
// front end: accepts items, pads the final block, splits limbs, queues work
`timescale 1ns / 1ps
module p1305_front
    import p1305_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] block_low,
    input  logic [63:0] block_high,
    input  logic [4:0]  byte_count,
    input  logic        last_block,
    output logic        q_valid,
    output blk_item_t   q_item,
    input  logic        q_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    blk_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [4:0]   nsat;
    logic [6:0]   shamt;
    logic [127:0] msg;
    logic [127:0] keep_mask;
    logic [127:0] padded;
    logic [127:0] chosen;
    blk_item_t    item_in;
    logic         push;

    // classify the incoming block and apply the final-block padding
    always_comb
    begin
        nsat      = (byte_count > 5'd16) ? 5'd16 : byte_count;
        shamt     = {nsat[3:0], 3'b000};
        msg       = {block_high, block_low};
        keep_mask = (128'd1 << shamt) - 128'd1;
        padded    = (msg & keep_mask) | (128'd1 << shamt);

        item_in.last   = last_block;
        item_in.absorb = 1'b1;
        item_in.hibit  = 1'b1;
        chosen         = msg;
        if (last_block)
        begin
            if (nsat == 5'd0)
            begin
                item_in.absorb = 1'b0;
                item_in.hibit  = 1'b0;
            end
            else if (nsat != 5'd16)
            begin
                item_in.hibit = 1'b0;
                chosen        = padded;
            end
        end
        item_in.limb[0] = chosen[25:0];
        item_in.limb[1] = chosen[51:26];
        item_in.limb[2] = chosen[77:52];
        item_in.limb[3] = chosen[103:78];
        item_in.limb[4] = {2'b00, chosen[127:104]};
    end

    assign in_stall = (count_reg == CNT_FULL);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

FILE: rtl/p1305_core.sv
// back end: accumulate, multiply by r one limb row per cycle, finalize the tag
`timescale 1ns / 1ps
module p1305_core
    import p1305_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  key_t        key,
    input  logic        q_valid,
    input  blk_item_t   q_item,
    output logic        q_pop,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [63:0] tag_low,
    output logic [63:0] tag_high,
    output core_stat_t  stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_FIN1 = 3'd2;
    localparam logic [2:0] S_FIN2 = 3'd3;
    localparam logic [2:0] S_FIN3 = 3'd4;
    localparam logic [2:0] ROWS   = 3'(NLIMB);

    logic [2:0]         state_reg, state_next;
    logic [ACC_W-1:0]   acc_reg [NLIMB];
    logic [ACC_W-1:0]   acc_next [NLIMB];
    logic [SUM_W-1:0]   hsum_reg [NLIMB];
    logic [SUM_W-1:0]   hsum_next [NLIMB];
    logic [FIN_W-1:0]   f_reg [NLIMB];
    logic [FIN_W-1:0]   f_next [NLIMB];
    logic [2:0]         row_reg, row_next;
    logic [ROW_W-1:0]   d_reg, d_next;
    logic [CARRY_W-1:0] c_reg, c_next;
    logic               last_reg, last_next;
    logic [63:0]        lo_reg, lo_next;
    logic [63:0]        hi_reg, hi_next;
    logic [63:0]        tag_low_reg, tag_low_next;
    logic [63:0]        tag_high_reg, tag_high_next;
    logic               out_valid_reg, out_valid_next;

    logic [COEF_W-1:0]        s5 [NLIMB];
    logic [COEF_W-1:0]        coef [NLIMB];
    logic [SUM_W+COEF_W-1:0]  prod [NLIMB];
    logic [ROW_W-1:0]         row_sum;
    logic [2:0]               row_sel;

    // multiplier bank: row k of the product h * r, wrapped terms use 5*r
    always_comb
    begin
        row_sel = (row_reg < ROWS) ? row_reg : 3'd0;
        row_sum = '0;
        for (int j = 0; j < NLIMB; j++)
        begin
            s5[j] = COEF_W'(key.r[j]) * COEF_W'(5);
            if (row_sel >= 3'(j))
            begin
                coef[j] = COEF_W'(key.r[3'(row_sel - 3'(j))]);
            end
            else
            begin
                coef[j] = s5[3'(row_sel + 3'(NLIMB - j))];
            end
            prod[j] = (SUM_W+COEF_W)'(hsum_reg[j]) * (SUM_W+COEF_W)'(coef[j]);
            row_sum = row_sum + ROW_W'(prod[j]);
        end
    end

    always_comb
    begin
        logic [ROW_W-1:0]   v;
        logic [CARRY_W-1:0] cf;
        logic [37:0]        h0;
        logic [FIN_W-1:0]   h [NLIMB];
        logic [FIN_W-1:0]   g [NLIMB];
        logic [FIN_W-1:0]   gc;
        logic [64:0]        sum_lo;

        state_next     = state_reg;
        row_next       = row_reg;
        d_next         = d_reg;
        c_next         = c_reg;
        last_next      = last_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        tag_low_next   = tag_low_reg;
        tag_high_next  = tag_high_reg;
        out_valid_next = out_valid_reg;
        q_pop          = 1'b0;
        for (int i = 0; i < NLIMB; i++)
        begin
            acc_next[i]  = acc_reg[i];
            hsum_next[i] = hsum_reg[i];
            f_next[i]    = f_reg[i];
            h[i]         = '0;
            g[i]         = '0;
        end
        v      = d_reg + ROW_W'(c_reg);
        cf     = v[ROW_W-1:LIMB_W];
        h0     = 38'(acc_reg[0]) + 38'(cf) * 38'd5;
        gc     = '0;
        sum_lo = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    last_next = q_item.last;
                    if (q_item.absorb)
                    begin
                        for (int i = 0; i < NLIMB; i++)
                        begin
                            hsum_next[i] = SUM_W'(acc_reg[i]) + SUM_W'(q_item.limb[i]);
                        end
                        if (q_item.hibit)
                        begin
                            hsum_next[4] = hsum_next[4] + SUM_W'(HIBIT);
                        end
                        row_next   = '0;
                        c_next     = '0;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_FIN1;
                    end
                end
            end
            S_MUL:
            begin
                if (row_reg < ROWS)
                begin
                    d_next = row_sum;
                end
                // carry runs one row behind the multiplier bank
                if (row_reg != 3'd0)
                begin
                    acc_next[3'(row_reg - 3'd1)] = ACC_W'(v[LIMB_W-1:0]);
                    c_next = cf;
                end
                if (row_reg == ROWS)
                begin
                    // fold the top carry back in times five
                    acc_next[0] = ACC_W'(h0[LIMB_W-1:0]);
                    acc_next[1] = acc_reg[1] + ACC_W'(h0[37:LIMB_W]);
                    state_next  = last_reg ? S_FIN1 : S_IDLE;
                end
                else
                begin
                    row_next = row_reg + 3'd1;
                end
            end
            S_FIN1:
            begin
                for (int i = 0; i < NLIMB; i++)
                begin
                    h[i] = FIN_W'(acc_reg[i]);
                end
                for (int i = 1; i < NLIMB; i++)
                begin
                    h[i]   = h[i] + (h[i-1] >> 26);
                    h[i-1] = h[i-1] & FIN_MASK;
                end
                h[0] = h[0] + (h[4] >> 26) * FIN_W'(5);
                h[1] = h[1] + (h[0] >> 26);
                h[0] = h[0] & FIN_MASK;
                h[4] = h[4] & FIN_MASK;
                for (int i = 0; i < NLIMB; i++)
                begin
                    f_next[i] = h[i];
                end
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                // h + 5 carries past 2^130 exactly when h >= p
                gc = FIN_W'(5);
                for (int i = 0; i < NLIMB; i++)
                begin
                    g[i] = f_reg[i] + gc;
                    gc   = g[i] >> 26;
                    g[i] = g[i] & FIN_MASK;
                end
                for (int i = 0; i < NLIMB; i++)
                begin
                    h[i] = (gc != '0) ? g[i] : f_reg[i];
                end
                lo_next = 64'(h[0]) | (64'(h[1]) << 26) | (64'(h[2]) << 52);
                hi_next = (64'(h[2]) >> 12) | (64'(h[3]) << 14) | (64'(h[4]) << 40);
                for (int i = 0; i < NLIMB; i++)
                begin
                    acc_next[i] = '0;
                end
                state_next = S_FIN3;
            end
            S_FIN3:
            begin
                sum_lo = 65'(lo_reg) + 65'(key.s_low);
                if (!out_valid_reg || !out_stall)
                begin
                    tag_low_next   = sum_lo[63:0];
                    tag_high_next  = hi_reg + key.s_high + 64'(sum_lo[64]);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            for (int i = 0; i < NLIMB; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            row_reg       <= row_next;
            for (int i = 0; i < NLIMB; i++)
            begin
                acc_reg[i] <= acc_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg        <= d_next;
        c_reg        <= c_next;
        last_reg     <= last_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        tag_low_reg  <= tag_low_next;
        tag_high_reg <= tag_high_next;
        for (int i = 0; i < NLIMB; i++)
        begin
            hsum_reg[i] <= hsum_next[i];
            f_reg[i]    <= f_next[i];
        end
    end

    assign out_valid = out_valid_reg;
    assign tag_low   = tag_low_reg;
    assign tag_high  = tag_high_reg;

    always_comb
    begin
        stat.pop      = q_pop;
        stat.acc_zero = 1'b1;
        for (int i = 0; i < NLIMB; i++)
        begin
            if (acc_reg[i] != '0)
            begin
                stat.acc_zero = 1'b0;
            end
        end
    end

endmodule

FILE: rtl/poly1305_mac.sv
// poly1305 authenticator top level: key registers, front end, queue, back end
// an item enters the queue in the cycle after it is accepted
// the back end takes a new absorbed block only after the five-row multiply and carry drain finish
// a last item then passes the finalize states FIN1, FIN2 and FIN3 before its tag appears
// reset: key registers and accumulator clear to zero, queue and output empty
`timescale 1ns / 1ps
module poly1305_mac
    import p1305_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] block_low,
    input  logic [63:0] block_high,
    input  logic [4:0]  byte_count,
    input  logic        last_block,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] tag_low,
    output logic [63:0] tag_high
);

    logic [63:0] r_low_reg, r_high_reg, s_low_reg, s_high_reg;
    logic [63:0] r_low_next, r_high_next, s_low_next, s_high_next;
    key_t        key;
    logic        q_valid;
    logic        q_pop;
    blk_item_t   q_item;
    core_stat_t  stat;

    always_comb
    begin
        r_low_next  = r_low_reg;
        r_high_next = r_high_reg;
        s_low_next  = s_low_reg;
        s_high_next = s_high_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_R_LOW:  r_low_next  = cfg_data;
                REG_R_HIGH: r_high_next = cfg_data;
                REG_S_LOW:  s_low_next  = cfg_data;
                REG_S_HIGH: s_high_next = cfg_data;
                default:    r_low_next  = r_low_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_low_reg  <= '0;
            r_high_reg <= '0;
            s_low_reg  <= '0;
            s_high_reg <= '0;
        end
        else
        begin
            r_low_reg  <= r_low_next;
            r_high_reg <= r_high_next;
            s_low_reg  <= s_low_next;
            s_high_reg <= s_high_next;
        end
    end

    // clamped r in 26-bit limbs
    always_comb
    begin
        key.r[0] = r_low_reg[25:0] & LIMB_MASK;
        key.r[1] = r_low_reg[51:26] & CLAMP_1;
        key.r[2] = {r_high_reg[13:0], r_low_reg[63:52]} & CLAMP_2;
        key.r[3] = r_high_reg[39:14] & CLAMP_3;
        key.r[4] = {2'b00, r_high_reg[63:40]} & CLAMP_4;
        key.s_low  = s_low_reg;
        key.s_high = s_high_reg;
    end

    p1305_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .block_low  (block_low),
        .block_high (block_high),
        .byte_count (byte_count),
        .last_block (last_block),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    p1305_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .tag_low   (tag_low),
        .tag_high  (tag_high),
        .stat      (stat)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pop |-> q_valid)
        else $error("back end took an item from an empty queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> q_valid)
        else $error("accepted item missing from queue");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> stat.acc_zero)
        else $error("accumulator not cleared when tag issued");

endmodule
